// ===== hdl/ctqs_pkg.sv =====
// Package: shared types and constants for the clipped textured quad setup block.
package ctqs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int QW = 33 + FRAC_BITS + 1;

   localparam logic [2:0] CSR_CLIP_LEFT   = 3'd0;
   localparam logic [2:0] CSR_CLIP_BOTTOM = 3'd1;
   localparam logic [2:0] CSR_CLIP_WIDTH  = 3'd2;
   localparam logic [2:0] CSR_CLIP_HEIGHT = 3'd3;
   localparam logic [2:0] CSR_MAX_VERTS   = 3'd4;

   localparam logic [1:0] ST_VERTEX = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_CULL   = 2'd2;

   typedef struct packed {
      logic               frame_start;
      logic signed [31:0] left_x;
      logic signed [31:0] top_y;
      logic signed [31:0] right_x;
      logic signed [31:0] bottom_y;
      logic signed [31:0] tex_left_u;
      logic signed [31:0] tex_top_v;
      logic signed [31:0] tex_right_u;
      logic signed [31:0] tex_bottom_v;
      logic        [31:0] rgba;
   } req_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic        [15:0] vertex_slot;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_u;
      logic signed [31:0] out_v;
      logic        [31:0] out_rgba;
      logic               last;
   } rsp_type;

endpackage

// ===== hdl/clipped_textured_quad_setup.sv =====
// Top level: scissor clip of one textured rectangle into six vertices.
//
// Usage: one request on req_ (valid/stall) carries a rectangle, its texture
// corners and a colour. The block answers with six vertex responses on rsp_,
// or a single response with status full or culled. csr_ writes the scissor
// box and vertex capacity; the user must write them only while the block
// is idle, since the block itself does not enforce it.
// A culled or full rectangle passes the test state and then shows its
// single response. A clipped one runs its left, right, top and bottom edge
// ratios through one shared restoring divider, then scales x, y, u and v of
// both corners through one shared multiplier, each in a multiply state and
// an add state, before its six vertices are emitted.
// req_stall is high from acceptance until the last response is taken.
// Reset (synchronous, active high) sets the CSR registers to their defaults,
// clears the vertex count and drops all pending work.
// When the receiver stalls, the response holds and the sequencer waits.
module clipped_textured_quad_setup (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ctqs_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ctqs_pkg::rsp_type     rsp_data,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [31:0]           csr_wdata
);

   localparam int FB = ctqs_pkg::FRAC_BITS;
   localparam int QW = ctqs_pkg::QW;
   localparam int CW = $clog2(QW + 1);
   localparam logic [QW-1:0] ONE_Q = QW'(1) << FB;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TEST = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MUL  = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;
   localparam logic [2:0] S_EMIT = 3'd5;
   localparam logic [2:0] S_ONE  = 3'd6;

   logic signed [31:0] clip_left_ff, clip_bottom_ff;
   logic        [30:0] clip_width_ff, clip_height_ff;
   logic        [15:0] max_vertices_ff, vertex_count_ff;

   logic [2:0]         state_ff;
   ctqs_pkg::req_type  req_ff;
   logic [1:0]         idx_ff;
   logic [2:0]         mi_ff;
   logic [2:0]         k_ff;
   logic [1:0]         ost_ff;

   logic [QW-1:0]      num_ff, rem_ff, quo_ff, den_ff;
   logic               qneg_ff, dzero_ff;
   logic [CW-1:0]      cnt_ff;
   logic [FB:0]        ratio_ff [4];

   logic signed [33+FB+1:0] prod_ff;
   logic signed [33:0]      coord_ff [8];

   logic signed [33:0] cr, ct, lx, ty, rx, by;
   assign cr = 34'(clip_left_ff) + 34'({1'b0, clip_width_ff});
   assign ct = 34'(clip_bottom_ff) + 34'({1'b0, clip_height_ff});
   assign lx = 34'(req_ff.left_x);
   assign ty = 34'(req_ff.top_y);
   assign rx = 34'(req_ff.right_x);
   assign by = 34'(req_ff.bottom_y);

   logic signed [33:0] w_s, h_s, tw_s, th_s;
   assign w_s  = rx - lx;
   assign h_s  = ty - by;
   assign tw_s = 34'(req_ff.tex_right_u) - 34'(req_ff.tex_left_u);
   assign th_s = 34'(req_ff.tex_top_v) - 34'(req_ff.tex_bottom_v);

   logic [15:0] vc_eff;
   assign vc_eff = req_ff.frame_start ? 16'd0 : vertex_count_ff;

   // ratio edge selection: 0 left, 1 right, 2 top, 3 bottom
   logic               edge_act;
   logic signed [33:0] edge_num, edge_den;
   always_comb begin
      edge_act = 1'b0;
      edge_num = '0;
      edge_den = w_s;
      unique case (idx_ff)
         2'd0: begin
            edge_act = lx < 34'(clip_left_ff);
            edge_num = 34'(clip_left_ff) - lx;
         end
         2'd1: begin
            edge_act = rx >= cr;
            edge_num = rx - cr;
         end
         2'd2: begin
            edge_act = ty >= ct;
            edge_num = ty - ct;
            edge_den = h_s;
         end
         default: begin
            edge_act = by < 34'(clip_bottom_ff);
            edge_num = 34'(clip_bottom_ff) - by;
            edge_den = h_s;
         end
      endcase
   end

   logic [QW-1:0] num_mag, den_mag;
   assign num_mag = edge_num[33] ? QW'(-edge_num) << FB : QW'(edge_num) << FB;
   assign den_mag = edge_den[33] ? QW'(-edge_den) : QW'(edge_den);

   logic [QW-1:0] rem_sh, rem_sub;
   logic          rem_ge;
   assign rem_sh  = {rem_ff[QW-2:0], num_ff[QW-1]};
   assign rem_ge  = rem_sh >= den_ff;
   assign rem_sub = rem_sh - den_ff;

   // clamp signed quotient (optionally ONE minus) into 0..ONE
   logic signed [QW:0] q_s, r_s;
   logic [FB:0]        r_clamp;
   always_comb begin
      q_s = qneg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (dzero_ff) q_s = '0;
      r_s = (idx_ff == 2'd1 || idx_ff == 2'd2) ? $signed({1'b0, ONE_Q}) - q_s : q_s;
      if (r_s < 0) r_clamp = '0;
      else if (r_s > $signed({1'b0, ONE_Q})) r_clamp = ONE_Q[FB:0];
      else r_clamp = r_s[FB:0];
   end

   // scale ops: mi -> span and ratio
   logic signed [33:0] m_span;
   logic [FB:0]        m_ratio;
   always_comb begin
      case (mi_ff[1:0])
         2'd0: m_span = w_s;
         2'd1: m_span = h_s;
         2'd2: m_span = tw_s;
         default: m_span = th_s;
      endcase
      case (mi_ff)
         3'd0, 3'd2: m_ratio = ratio_ff[0];
         3'd1, 3'd3: m_ratio = ratio_ff[2];
         3'd4, 3'd6: m_ratio = ratio_ff[1];
         default:    m_ratio = ratio_ff[3];
      endcase
   end

   logic signed [33:0] m_base, m_sum;
   always_comb begin
      case (mi_ff[1:0])
         2'd0: m_base = lx;
         2'd1: m_base = by;
         2'd2: m_base = 34'(req_ff.tex_left_u);
         default: m_base = 34'(req_ff.tex_bottom_v);
      endcase
      m_sum = m_base + 34'(prod_ff >>> FB);
   end

   logic signed [33:0] m_sat;
   always_comb begin
      if (m_sum > 34'sd2147483647) m_sat = 34'sd2147483647;
      else if (m_sum < -34'sd2147483648) m_sat = -34'sd2147483648;
      else m_sat = m_sum;
   end

   // emission corner: TL=0 BL=1 BR=2 TL BR TR=3
   logic [1:0] corner;
   always_comb begin
      case (k_ff)
         3'd0, 3'd3: corner = 2'd0;
         3'd1:       corner = 2'd1;
         3'd5:       corner = 2'd3;
         default:    corner = 2'd2;
      endcase
   end

   always_comb begin
      rsp_data = '0;
      rsp_data.last = 1'b1;
      rsp_data.status = ost_ff;
      if (state_ff == S_EMIT) begin
         rsp_data.status      = ctqs_pkg::ST_VERTEX;
         rsp_data.vertex_slot = vc_eff + 16'(k_ff);
         rsp_data.out_x = (corner == 2'd0 || corner == 2'd1) ?
                          coord_ff[0][31:0] : coord_ff[4][31:0];
         rsp_data.out_y = (corner == 2'd0 || corner == 2'd3) ?
                          coord_ff[1][31:0] : coord_ff[5][31:0];
         rsp_data.out_u = (corner == 2'd0 || corner == 2'd1) ?
                          coord_ff[2][31:0] : coord_ff[6][31:0];
         rsp_data.out_v = (corner == 2'd0 || corner == 2'd3) ?
                          coord_ff[3][31:0] : coord_ff[7][31:0];
         rsp_data.out_rgba = req_ff.rgba;
         rsp_data.last = k_ff == 3'd5;
      end
   end

   assign rsp_valid = state_ff == S_EMIT || state_ff == S_ONE;
   assign req_stall = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff    <= -32'sd1073741824;
         clip_bottom_ff  <= -32'sd1073741824;
         clip_width_ff   <= 31'h7FFFFFFF;
         clip_height_ff  <= 31'h7FFFFFFF;
         max_vertices_ff <= 16'hFFFF;
      end else if (csr_write) begin
         unique case (csr_index)
            ctqs_pkg::CSR_CLIP_LEFT:   clip_left_ff    <= csr_wdata;
            ctqs_pkg::CSR_CLIP_BOTTOM: clip_bottom_ff  <= csr_wdata;
            ctqs_pkg::CSR_CLIP_WIDTH:  clip_width_ff   <= csr_wdata[30:0];
            ctqs_pkg::CSR_CLIP_HEIGHT: clip_height_ff  <= csr_wdata[30:0];
            ctqs_pkg::CSR_MAX_VERTS:   max_vertices_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         vertex_count_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_TEST;
            S_TEST: begin
               if (17'(vc_eff) + 17'd6 > 17'(max_vertices_ff)) begin
                  ost_ff   <= ctqs_pkg::ST_FULL;
                  state_ff <= S_ONE;
               end else if (lx >= cr || ty < 34'(clip_bottom_ff) ||
                            rx < 34'(clip_left_ff) || by >= ct) begin
                  ost_ff   <= ctqs_pkg::ST_CULL;
                  state_ff <= S_ONE;
               end else begin
                  idx_ff   <= 2'd0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (cnt_ff == '0) begin
                  num_ff   <= num_mag;
                  den_ff   <= den_mag;
                  rem_ff   <= '0;
                  quo_ff   <= '0;
                  qneg_ff  <= edge_num[33] ^ edge_den[33];
                  dzero_ff <= edge_den == '0;
                  cnt_ff   <= CW'(1);
               end else if (cnt_ff <= CW'(QW)) begin
                  rem_ff <= rem_ge ? rem_sub : rem_sh;
                  quo_ff <= {quo_ff[QW-2:0], rem_ge};
                  num_ff <= {num_ff[QW-2:0], 1'b0};
                  cnt_ff <= cnt_ff + CW'(1);
               end else begin
                  if (edge_act) ratio_ff[idx_ff] <= r_clamp;
                  else ratio_ff[idx_ff] <= (idx_ff == 2'd1 || idx_ff == 2'd2) ?
                                           ONE_Q[FB:0] : '0;
                  cnt_ff <= '0;
                  idx_ff <= idx_ff + 2'd1;
                  if (idx_ff == 2'd3) begin
                     mi_ff    <= '0;
                     state_ff <= S_MUL;
                  end
               end
            end
            S_MUL: begin
               prod_ff  <= m_span * $signed({1'b0, m_ratio});
               state_ff <= S_ADD;
            end
            S_ADD: begin
               coord_ff[mi_ff] <= m_sat;
               mi_ff <= mi_ff + 3'd1;
               if (mi_ff == 3'd7) begin
                  k_ff     <= '0;
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_MUL;
               end
            end
            S_EMIT: if (!rsp_stall) begin
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd5) begin
                  vertex_count_ff <= vc_eff + 16'd6;
                  state_ff        <= S_IDLE;
               end
            end
            S_ONE: if (!rsp_stall) begin
               if (req_ff.frame_start) vertex_count_ff <= '0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
   end

`ifndef SYNTHESIS
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("response while accepting");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");
   a_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && k_ff == 3'd5 && !rsp_stall |=>
      vertex_count_ff == $past(vc_eff) + 16'd6) else $error("vertex count");
`endif

endmodule

// ===== dv/clipped_textured_quad_setup_test.sv =====
// Testbench for clipped_textured_quad_setup: rectangles checked against a vertex predictor.
module clipped_textured_quad_setup_test;
   timeunit 1ns;
   timeprecision 1ps;

   class vertex_scoreboard;
      longint clip_l, clip_b, clip_w, clip_h;
      int unsigned vert_cap, vert_count;
      ctqs_pkg::rsp_type vertex_queue[$];
      int errors;

      function new();
         clip_l = -1073741824;
         clip_b = -1073741824;
         clip_w = 2147483647;
         clip_h = 2147483647;
         vert_cap = 65535;
         vert_count = 0;
         errors = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            ctqs_pkg::CSR_CLIP_LEFT:   clip_l = longint'(signed'(val));
            ctqs_pkg::CSR_CLIP_BOTTOM: clip_b = longint'(signed'(val));
            ctqs_pkg::CSR_CLIP_WIDTH:  clip_w = longint'(val[30:0]);
            ctqs_pkg::CSR_CLIP_HEIGHT: clip_h = longint'(val[30:0]);
            ctqs_pkg::CSR_MAX_VERTS:   vert_cap = val[15:0];
            default: ;
         endcase
      endfunction

      function longint ratio(longint num, longint den);
         longint q;
         q = (den == 0) ? 0 : (num * (64'sd1 <<< ctqs_pkg::FRAC_BITS)) / den;
         if (q < 0) q = 0;
         if (q > (64'sd1 <<< ctqs_pkg::FRAC_BITS)) q = 64'sd1 <<< ctqs_pkg::FRAC_BITS;
         return q;
      endfunction

      function logic [31:0] lerp(longint base, longint span, longint r);
         longint p, v;
         longint one;
         one = 64'sd1 <<< ctqs_pkg::FRAC_BITS;
         p = span * r;
         v = base + ((p >= 0) ? p / one : -((-p + one - 1) / one));
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         if (v < -64'sd2147483648) v = -64'sd2147483648;
         return v[31:0];
      endfunction

      function void note_request(ctqs_pkg::req_type rq);
         longint lx, ty, rx, by, cr, ct, w, h, tw, th, lr, rr, tr, br, one;
         logic [31:0] x[4], y[4], u[4], v[4];
         int corner[6];
         ctqs_pkg::rsp_type r;
         corner = '{0, 1, 2, 0, 2, 3};
         one = 64'sd1 <<< ctqs_pkg::FRAC_BITS;
         lx = rq.left_x; ty = rq.top_y; rx = rq.right_x; by = rq.bottom_y;
         r = '0;
         r.last = 1'b1;
         if (rq.frame_start) vert_count = 0;
         if (vert_count + 6 > vert_cap) begin
            r.status = ctqs_pkg::ST_FULL;
            vertex_queue.push_back(r);
            return;
         end
         cr = clip_l + clip_w;
         ct = clip_b + clip_h;
         if (lx >= cr || ty < clip_b || rx < clip_l || by >= ct) begin
            r.status = ctqs_pkg::ST_CULL;
            vertex_queue.push_back(r);
            return;
         end
         w = rx - lx; h = ty - by;
         tw = longint'(rq.tex_right_u) - rq.tex_left_u;
         th = longint'(rq.tex_top_v) - rq.tex_bottom_v;
         lr = (lx < clip_l) ? ratio(clip_l - lx, w) : 0;
         rr = one;
         if (rx >= cr) begin
            rr = (w == 0) ? one : one - (((rx - cr) * one) / w);
            if (rr < 0) rr = 0;
            if (rr > one) rr = one;
         end
         tr = one;
         if (ty >= ct) begin
            tr = (h == 0) ? one : one - (((ty - ct) * one) / h);
            if (tr < 0) tr = 0;
            if (tr > one) tr = one;
         end
         br = (by < clip_b) ? ratio(clip_b - by, h) : 0;
         x[0] = lerp(lx, w, lr);
         y[0] = lerp(by, h, tr);
         u[0] = lerp(rq.tex_left_u, tw, lr);
         v[0] = lerp(rq.tex_bottom_v, th, tr);
         x[2] = lerp(lx, w, rr);
         y[2] = lerp(by, h, br);
         u[2] = lerp(rq.tex_left_u, tw, rr);
         v[2] = lerp(rq.tex_bottom_v, th, br);
         x[1] = x[0]; y[1] = y[2]; u[1] = u[0]; v[1] = v[2];
         x[3] = x[2]; y[3] = y[0]; u[3] = u[2]; v[3] = v[0];
         for (int k = 0; k < 6; k++) begin
            r.status = ctqs_pkg::ST_VERTEX;
            r.vertex_slot = 16'(vert_count + k);
            r.out_x = x[corner[k]];
            r.out_y = y[corner[k]];
            r.out_u = u[corner[k]];
            r.out_v = v[corner[k]];
            r.out_rgba = rq.rgba;
            r.last = (k == 5);
            vertex_queue.push_back(r);
         end
         vert_count = (vert_count + 6) & 16'hFFFF;
      endfunction

      function void check_vertex(ctqs_pkg::rsp_type got);
         ctqs_pkg::rsp_type e;
         if (vertex_queue.size() == 0) begin
            $error("unexpected response %h", got);
            errors++;
            return;
         end
         e = vertex_queue.pop_front();
         if (got.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, got.status); errors++;
         end
         if (got.vertex_slot !== e.vertex_slot) begin
            $error("vertex_slot exp %0d got %0d", e.vertex_slot, got.vertex_slot); errors++;
         end
         if (got.out_x !== e.out_x) begin
            $error("out_x exp %h got %h", e.out_x, got.out_x); errors++;
         end
         if (got.out_y !== e.out_y) begin
            $error("out_y exp %h got %h", e.out_y, got.out_y); errors++;
         end
         if (got.out_u !== e.out_u) begin
            $error("out_u exp %h got %h", e.out_u, got.out_u); errors++;
         end
         if (got.out_v !== e.out_v) begin
            $error("out_v exp %h got %h", e.out_v, got.out_v); errors++;
         end
         if (got.out_rgba !== e.out_rgba) begin
            $error("out_rgba exp %h got %h", e.out_rgba, got.out_rgba); errors++;
         end
         if (got.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, got.last); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ctqs_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ctqs_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   vertex_scoreboard board = new();
   int quiet_cycles = 0;
   bit calm_period = 1'b0;
   bit hold_off = 1'b0;
   bit pressure_go = 1'b0;

   clipped_textured_quad_setup i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_vertex(rsp_data);
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles > 20000) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver: random stall, long hold-off on request, no stall in calm periods
   always @(posedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (calm_period) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < 10);
   end

   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off = 1'b1;
      repeat (1500) @(posedge clock);
      hold_off = 1'b0;
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.write_reg(idx, val);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_rect(ctqs_pkg::req_type rq);
      while (!calm_period && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.vertex_queue.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic ctqs_pkg::req_type random_rect(bit wild);
      ctqs_pkg::req_type rq;
      logic [319:0] fill;
      int sx, sy;
      fill = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
      rq = fill[$bits(ctqs_pkg::req_type)-1:0];
      rq.frame_start = ($urandom_range(19) == 0);
      if (!wild) begin
         sx = $urandom_range(300000);
         sy = $urandom_range(300000);
         rq.left_x = $signed($urandom_range(400000)) - 200000;
         rq.bottom_y = $signed($urandom_range(400000)) - 200000;
         rq.right_x = rq.left_x + sx;
         rq.top_y = rq.bottom_y + sy;
      end
      return rq;
   endfunction

   function automatic ctqs_pkg::req_type make_rect(int lx, int ty, int rx, int by);
      ctqs_pkg::req_type rq;
      logic [319:0] fill;
      fill = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
      rq = fill[$bits(ctqs_pkg::req_type)-1:0];
      rq.frame_start = 1'b0;
      rq.left_x = lx; rq.top_y = ty; rq.right_x = rx; rq.bottom_y = by;
      return rq;
   endfunction

   initial begin
      ctqs_pkg::req_type rq;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // default box, extremes
      rq = make_rect(32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000);
      rq.frame_start = 1'b1;
      send_rect(rq);
      send_rect(make_rect(0, 0, 0, 0));
      rq = make_rect(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
      rq.tex_left_u = 32'sh80000000; rq.tex_right_u = 32'sh7FFFFFFF;
      rq.tex_top_v = 32'sh7FFFFFFF; rq.tex_bottom_v = 32'sh80000000;
      rq.rgba = 32'hFFFFFFFF;
      send_rect(rq);
      rq = make_rect(-32'sd10, 0, 10, 0);
      rq.rgba = 32'h0;
      send_rect(rq);
      drain();
      write_csr(ctqs_pkg::CSR_CLIP_LEFT, 32'sd0);
      write_csr(ctqs_pkg::CSR_CLIP_BOTTOM, 32'sd0);
      write_csr(ctqs_pkg::CSR_CLIP_WIDTH, 32'd100000);
      write_csr(ctqs_pkg::CSR_CLIP_HEIGHT, 32'd100000);
      write_csr(ctqs_pkg::CSR_MAX_VERTS, 32'd30);
      write_csr(3'd7, 32'hDEADBEEF);
      send_rect(make_rect(-50000, 150000, 150000, -50000));
      send_rect(make_rect(100000, 50000, 200000, 0));
      send_rect(make_rect(0, -1, 50000, -100));
      send_rect(make_rect(-100, 50000, -1, 0));
      send_rect(make_rect(0, 200000, 50000, 100000));
      send_rect(make_rect(10, 20, 90000, 10));
      send_rect(make_rect(20000, 1000, 10000, 90000));
      send_rect(make_rect(-5, 500, -5, 300));
      send_rect(make_rect(10, 10, 20, 5));
      send_rect(make_rect(10, 10, 20, 5));
      send_rect(make_rect(10, 10, 20, 5));
      rq = make_rect(10, 10, 20, 5);
      rq.frame_start = 1'b1;
      send_rect(rq);
      drain();
      write_csr(ctqs_pkg::CSR_CLIP_LEFT, 32'sh80000000);
      write_csr(ctqs_pkg::CSR_CLIP_BOTTOM, 32'sh80000000);
      write_csr(ctqs_pkg::CSR_CLIP_WIDTH, 32'h7FFFFFFF);
      write_csr(ctqs_pkg::CSR_CLIP_HEIGHT, 32'h0);
      write_csr(ctqs_pkg::CSR_MAX_VERTS, 32'hFFFF);
      for (int i = 0; i < 10; i++) send_rect(random_rect(1'b1));
      drain();
      write_csr(ctqs_pkg::CSR_CLIP_LEFT, -32'sd100000);
      write_csr(ctqs_pkg::CSR_CLIP_BOTTOM, -32'sd100000);
      write_csr(ctqs_pkg::CSR_CLIP_WIDTH, 32'd200000);
      write_csr(ctqs_pkg::CSR_CLIP_HEIGHT, 32'd200000);
      write_csr(ctqs_pkg::CSR_MAX_VERTS, 32'd120);
      pressure_go = 1'b1;
      for (int i = 0; i < 45; i++) send_rect(random_rect($urandom_range(4) == 0));
      drain();
      calm_period = 1'b1;
      write_csr(ctqs_pkg::CSR_CLIP_LEFT, $urandom);
      write_csr(ctqs_pkg::CSR_CLIP_BOTTOM, $urandom);
      write_csr(ctqs_pkg::CSR_CLIP_WIDTH, 32'h0);
      write_csr(ctqs_pkg::CSR_CLIP_HEIGHT, 32'h7FFFFFFF);
      write_csr(ctqs_pkg::CSR_MAX_VERTS, 32'd0);
      for (int i = 0; i < 5; i++) send_rect(random_rect(1'b0));
      drain();
      write_csr(ctqs_pkg::CSR_CLIP_LEFT, -32'sd150000);
      write_csr(ctqs_pkg::CSR_CLIP_BOTTOM, -32'sd150000);
      write_csr(ctqs_pkg::CSR_CLIP_WIDTH, 32'd250000);
      write_csr(ctqs_pkg::CSR_CLIP_HEIGHT, 32'd250000);
      write_csr(ctqs_pkg::CSR_MAX_VERTS, 32'hFFFF);
      for (int i = 0; i < 20; i++) send_rect(random_rect(1'b0));
      calm_period = 1'b0;
      for (int i = 0; i < 20; i++) send_rect(random_rect($urandom_range(4) == 0));
      drain();
      if (board.errors == 0 && board.vertex_queue.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== files.f =====
hdl/ctqs_pkg.sv
hdl/clipped_textured_quad_setup.sv
dv/clipped_textured_quad_setup_test.sv
